// ----- rtl/m3i_pkg.sv -----
// shared constants, widths and the front-to-back request type of the 3x3 inverse unit
// no dependencies
`default_nettype none

package m3i_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SHIFT     = 2 * FRAC_BITS;
    localparam int NE        = 9;
    localparam int EW        = 32;
    localparam int PW        = 2 * EW;
    localparam int CW        = PW + 1;
    localparam int CLW       = CW - EW;
    localparam int PLW       = EW + CLW + 1;
    localparam int DW        = EW + CW + 1;
    localparam int QB        = EW + 1;
    localparam int NS        = QB + 1;
    localparam int MW        = CW + SHIFT;
    localparam int RW        = DW + QB + 1;
    localparam int NF        = 7;
    localparam int QD        = 4;
    localparam int QAW       = $clog2(QD);

    // cofactor k = a[p]*a[q] - a[r]*a[s], adjugate in row-major order
    localparam logic [3:0] COF_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd8, 4'd1}, '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd5, 4'd6, 4'd8, 4'd3}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd2, 4'd3, 4'd5, 4'd0},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd1, 4'd6, 4'd7, 4'd0}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    typedef struct packed {
        logic [NE-1:0][CW-1:0] cof;
        logic [DW-1:0]         det;
        logic                  singular;
    } m3i_item_t;

endpackage

`default_nettype wire

// ----- rtl/m3i_front.sv -----
// front pipeline: input register, cofactor products, determinant and singular check
// depends on m3i_pkg
`default_nettype none

module m3i_front import m3i_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [NE*EW-1:0] s_tdata,    // a00 a01 a02 a10 a11 a12 a20 a21 a22, 32 bits each
    input  wire logic             queue_full,
    output logic                  item_valid,
    output m3i_item_t             item
);

    logic [NF-1:0] v_reg;
    logic          en;

    logic signed [EW-1:0]  a_reg     [NE];
    logic signed [PW-1:0]  prod_reg  [NE][2];
    logic signed [EW-1:0]  a1_reg    [3];
    logic signed [EW-1:0]  a2_reg    [3];
    logic signed [CW-1:0]  cof2_reg  [NE];
    logic signed [CW-1:0]  cof3_reg  [NE];
    logic signed [CW-1:0]  cof4_reg  [NE];
    logic signed [CW-1:0]  cof5_reg  [NE];
    logic signed [PW-1:0]  ph_reg    [3];
    logic signed [PLW-1:0] pl_reg    [3];
    logic signed [DW-1:0]  t_reg     [3];
    logic signed [DW-1:0]  det_reg;
    m3i_item_t             item_reg;

    assign en         = !v_reg[NF-1] || !queue_full;
    assign s_tready   = en;
    assign item_valid = v_reg[NF-1];
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NF-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
            begin
                a_reg[k] <= $signed(s_tdata[k*EW +: EW]);
            end
            for (int k = 0; k < NE; k++)
            begin
                prod_reg[k][0] <= a_reg[COF_IDX[k][0]] * a_reg[COF_IDX[k][1]];
                prod_reg[k][1] <= a_reg[COF_IDX[k][2]] * a_reg[COF_IDX[k][3]];
                cof2_reg[k]    <= $signed({prod_reg[k][0][PW-1], prod_reg[k][0]})
                                - $signed({prod_reg[k][1][PW-1], prod_reg[k][1]});
                cof3_reg[k]    <= cof2_reg[k];
                cof4_reg[k]    <= cof3_reg[k];
                cof5_reg[k]    <= cof4_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                a1_reg[j] <= a_reg[j];
                a2_reg[j] <= a1_reg[j];
                // split the wide cofactor: signed upper 32 bits, unsigned lower 33 bits
                ph_reg[j] <= a2_reg[j] * $signed(cof2_reg[3*j][CW-1:CLW]);
                pl_reg[j] <= $signed({{(PLW-EW){a2_reg[j][EW-1]}}, a2_reg[j]})
                           * $signed({{(PLW-CLW){1'b0}}, cof2_reg[3*j][CLW-1:0]});
                t_reg[j]  <= $signed({{(DW-PW-CLW){ph_reg[j][PW-1]}}, ph_reg[j], {CLW{1'b0}}})
                           + $signed({{(DW-PLW){pl_reg[j][PLW-1]}}, pl_reg[j]});
            end
            det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
            for (int k = 0; k < NE; k++)
            begin
                item_reg.cof[k] <= cof5_reg[k];
            end
            item_reg.det      <= det_reg;
            item_reg.singular <= (det_reg == '0);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/m3i_queue.sv -----
// short request queue between the front and back pipelines
// depends on m3i_pkg
`default_nettype none

module m3i_queue import m3i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  m3i_item_t  push_item,
    output logic       full,
    output logic       head_valid,
    output m3i_item_t  head_item,
    input  wire logic  pop
);

    m3i_item_t        mem_reg [QD];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             push;

    assign full       = (count_reg == (QAW+1)'(QD));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign push       = push_valid && !full;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QD))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ----- rtl/m3i_back.sv -----
// back pipeline: sign handling, overflow check, one quotient bit per stage for nine lanes, saturation
// depends on m3i_pkg
`default_nettype none

module m3i_back import m3i_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  m3i_item_t             head_item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [NE*EW-1:0]      m_tdata,    // inv00 inv01 inv02 inv10 .. inv22, 32 bits each
    output logic [1:0]            m_tuser     // singular, saturated
);

    localparam logic [QB-1:0] POS_MAX = {{(QB-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic [QB-1:0] NEG_MAX = {{(QB-EW){1'b0}}, 1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] SAT_HI  = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_LO  = {1'b1, {(EW-1){1'b0}}};

    logic             en;
    logic [NS:0]      v_reg;
    logic [RW-1:0]    rem_reg  [NS+1][NE];
    logic [RW-1:0]    rem_next [NS+1][NE];
    logic [QB-1:0]    q_reg    [NS+1][NE];
    logic [QB-1:0]    q_next   [NS+1][NE];
    logic [NE-1:0]    ovf_reg  [NS+1];
    logic [NE-1:0]    ovf_next [NS+1];
    logic [NE-1:0]    neg_reg  [NS+1];
    logic [NE-1:0]    neg_next [NS+1];
    logic [DW-1:0]    dv_reg   [NS+1];
    logic [DW-1:0]    dv_next  [NS+1];
    logic [NS:0]      sing_reg;
    logic [NS:0]      sing_next;
    logic             out_v_reg;
    logic [NE*EW-1:0] data_reg;
    logic [NE*EW-1:0] data_next;
    logic [1:0]       user_reg;
    logic [1:0]       user_next;

    assign en       = !out_v_reg || m_tready;
    assign pop      = head_valid && en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_comb
    begin
        logic [CW-1:0] cmag;
        logic [RW-1:0] sd;
        logic          ge;
        logic          sat_any;
        logic          sat;
        logic [EW-1:0] v;
        int            b;

        // prep: magnitudes and result signs
        dv_next[0]   = head_item.det[DW-1] ? DW'(-head_item.det) : head_item.det;
        sing_next[0] = head_item.singular;
        ovf_next[0]  = '0;
        for (int k = 0; k < NE; k++)
        begin
            cmag = head_item.cof[k][CW-1] ? CW'(-head_item.cof[k]) : head_item.cof[k];
            rem_next[0][k] = {{(RW-MW){1'b0}}, cmag, {SHIFT{1'b0}}};
            q_next[0][k]   = '0;
            neg_next[0][k] = head_item.cof[k][CW-1] ^ head_item.det[DW-1];
        end

        // first step only checks for a quotient of 2^QB or more
        for (int s = 1; s <= NS; s++)
        begin
            b            = NS - s;
            dv_next[s]   = dv_reg[s-1];
            sing_next[s] = sing_reg[s-1];
            neg_next[s]  = neg_reg[s-1];
            ovf_next[s]  = ovf_reg[s-1];
            for (int k = 0; k < NE; k++)
            begin
                sd = {{(RW-DW){1'b0}}, dv_reg[s-1]} << b;
                ge = (rem_reg[s-1][k] >= sd);
                rem_next[s][k] = rem_reg[s-1][k];
                q_next[s][k]   = q_reg[s-1][k];
                if (b == QB)
                begin
                    ovf_next[s][k] = ge;
                end
                else if (ge)
                begin
                    rem_next[s][k] = rem_reg[s-1][k] - sd;
                    q_next[s][k][b[$clog2(QB)-1:0]] = 1'b1;
                end
            end
        end

        sat_any = 1'b0;
        for (int k = 0; k < NE; k++)
        begin
            if (neg_reg[NS][k])
            begin
                sat = ovf_reg[NS][k] || (q_reg[NS][k] > NEG_MAX);
                v   = sat ? SAT_LO : EW'(-q_reg[NS][k][EW-1:0]);
            end
            else
            begin
                sat = ovf_reg[NS][k] || (q_reg[NS][k] > POS_MAX);
                v   = sat ? SAT_HI : q_reg[NS][k][EW-1:0];
            end
            sat_any = sat_any || sat;
            data_next[k*EW +: EW] = sing_reg[NS] ? '0 : v;
        end
        user_next = {!sing_reg[NS] && sat_any, sing_reg[NS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[NS-1:0], head_valid};
            out_v_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            ovf_reg  <= ovf_next;
            neg_reg  <= neg_next;
            dv_reg   <= dv_next;
            sing_reg <= sing_next;
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("singular result with nonzero data or saturation");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("divider pipeline moved while stalled");
    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> v_reg[0])
        else $error("popped request not in first stage");
`endif

endmodule

`default_nettype wire

// ----- rtl/matrix3_inverse_unit.sv -----
// Inverse of a 3x3 signed Q16.16 matrix by adjugate and determinant, one request per
// clock unless the output stalls. A request passes the front pipeline (products, cofactors,
// determinant, singular check), a 4-entry queue, then the back pipeline, where each step
// of a restoring divider after the first resolves one quotient bit for all nine entries at
// once and the first step only checks for overflow. Output entries truncate toward zero
// and saturate to 32 bits; a zero determinant gives zeros.
// depends on m3i_pkg, m3i_front, m3i_queue, m3i_back
`default_nettype none

module matrix3_inverse_unit import m3i_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [NE*EW-1:0] s_tdata,    // a00 a01 a02 a10 a11 a12 a20 a21 a22
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [NE*EW-1:0]      m_tdata,    // inv00 inv01 inv02 inv10 .. inv22
    output logic [1:0]            m_tuser     // singular, saturated
);

    logic      item_valid;
    m3i_item_t item;
    logic      queue_full;
    logic      head_valid;
    m3i_item_t head_item;
    logic      pop;

    m3i_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .item_valid (item_valid),
        .item       (item)
    );

    m3i_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_item  (item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    m3i_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// testbench for matrix3_inverse_unit: 3x3 fixed-point inverse with saturation and singular flag
// depends on m3i_pkg and the rtl of matrix3_inverse_unit
`timescale 1ns / 1ps

module tb import m3i_pkg::*;
();

    typedef struct {
        logic [NE*EW-1:0] inv;
        logic [1:0]       flags;
    } inv_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [NE*EW-1:0] s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [NE*EW-1:0] m_tdata;
    logic [1:0]       m_tuser;

    inv_result_t pending_inv[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_singular = 0;
    int          n_sat = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;

    matrix3_inverse_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // a00 a01 a02 a10 a11 a12 a20 a21 a22
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // inv00 .. inv22
        .m_tuser  (m_tuser)     // singular, saturated
    );

    always #2 clk = ~clk;

    // exact adjugate / determinant inverse, truncated toward zero and clipped
    function automatic inv_result_t invert_matrix(input logic [NE*EW-1:0] mat);
        logic signed [127:0] a [NE];
        logic signed [127:0] cof [NE];
        logic signed [127:0] det;
        logic signed [127:0] num;
        logic signed [127:0] quo;
        inv_result_t         r;
        bit                  sat;
        sat = 1'b0;
        r.inv = '0;
        for (int k = 0; k < NE; k++)
            a[k] = $signed(mat[k*EW +: EW]);
        cof[0] = a[4]*a[8] - a[7]*a[5];
        cof[1] = a[2]*a[7] - a[8]*a[1];
        cof[2] = a[1]*a[5] - a[4]*a[2];
        cof[3] = a[5]*a[6] - a[8]*a[3];
        cof[4] = a[0]*a[8] - a[6]*a[2];
        cof[5] = a[2]*a[3] - a[5]*a[0];
        cof[6] = a[3]*a[7] - a[6]*a[4];
        cof[7] = a[1]*a[6] - a[7]*a[0];
        cof[8] = a[0]*a[4] - a[3]*a[1];
        det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
        if (det == 0)
        begin
            r.flags = 2'b01;
            return r;
        end
        for (int k = 0; k < NE; k++)
        begin
            num = cof[k] <<< SHIFT;
            quo = num / det;    // signed division truncates toward zero
            if (quo > 128'sh7FFFFFFF)
            begin
                quo = 128'sh7FFFFFFF;
                sat = 1'b1;
            end
            else if (quo < -128'sh80000000)
            begin
                quo = -128'sh80000000;
                sat = 1'b1;
            end
            r.inv[k*EW +: EW] = quo[EW-1:0];
        end
        r.flags = {sat, 1'b0};
        return r;
    endfunction

    // valid stays high between back-to-back requests and drops only while idling
    task automatic send_matrix(input logic [NE*EW-1:0] mat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        pending_inv.push_back(invert_matrix(mat));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // receiver side ready, with an optional long hold-off
    always @(posedge clk)
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        inv_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_inv.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                n_errors++;
            end
            else
            begin
                exp_r = pending_inv.pop_front();
                for (int k = 0; k < NE; k++)
                    if (m_tdata[k*EW +: EW] !== exp_r.inv[k*EW +: EW])
                    begin
                        $error("inv%0d%0d expected %h got %h", k / 3, k % 3,
                               exp_r.inv[k*EW +: EW], m_tdata[k*EW +: EW]);
                        n_errors++;
                    end
                if (m_tuser[0] !== exp_r.flags[0])
                begin
                    $error("singular expected %b got %b", exp_r.flags[0], m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[1] !== exp_r.flags[1])
                begin
                    $error("saturated expected %b got %b", exp_r.flags[1], m_tuser[1]);
                    n_errors++;
                end
                n_singular += exp_r.flags[0];
                n_sat += exp_r.flags[1];
                n_checked++;
            end
        end
    end

    function automatic logic [EW-1:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
            2: return {{16{1'b0}}, 16'($urandom())};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'($signed($urandom_range(8)) - 4) << 16;
            default: return $urandom_range(3) - 1;
        endcase
    endfunction

    function automatic logic [NE*EW-1:0] rand_matrix();
        logic [NE*EW-1:0] m;
        int               sh;
        for (int k = 0; k < NE; k++)
            m[k*EW +: EW] = rand_entry();
        case ($urandom_range(9))
            0: m[3*EW +: 3*EW] = m[0 +: 3*EW];    // repeated row, singular
            1: m[6*EW +: 3*EW] = '0;
            2:
            begin
                // near-identity scaled down, large inverse
                sh = $urandom_range(31);
                m = '0;
                for (int k = 0; k < NE; k += 4)
                    m[k*EW +: EW] = ($urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000) >>> sh;
            end
            default: ;
        endcase
        return m;
    endfunction

    function automatic logic [NE*EW-1:0] diag(input logic [EW-1:0] d0, d1, d2);
        logic [NE*EW-1:0] m;
        m = '0;
        m[0 +: EW] = d0;
        m[4*EW +: EW] = d1;
        m[8*EW +: EW] = d2;
        return m;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_inv.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [NE*EW-1:0] m;
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'h0002_0000, 32'hFFFC_0000, 32'h0000_8000));
        send_matrix('0);
        send_matrix({NE{32'h7FFF_FFFF}});
        send_matrix({NE{32'h8000_0000}});
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag(32'h0000_0003, 32'h0001_0000, 32'h0001_0000));
        send_matrix({NE{32'hFFFF_FFFF}});
        send_matrix({NE{32'hAAAA_5555}});
        send_matrix({NE{32'h5555_AAAA}});
        m = diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        m[1*EW +: EW] = 32'h7FFF_FFFF;
        m[5*EW +: EW] = 32'h8000_0000;
        m[6*EW +: EW] = 32'h7FFF_FFFF;
        send_matrix(m);
        m = '0;
        m[2*EW +: EW] = 32'h0001_0000;
        m[4*EW +: EW] = 32'h0003_0000;
        m[6*EW +: EW] = 32'hFFFF_0000;
        send_matrix(m);    // permutation-like, exact thirds truncated
        for (int k = 0; k < 5; k++)
            send_matrix(rand_matrix());
        wait_drained();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < count; k++)
            send_matrix(rand_matrix());
        wait_drained();
    endtask

    // receiver stalls long enough for the pipeline and queue to back up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                recv_hold <= 1'b1;
                repeat (200) @(posedge clk);
                recv_hold <= 1'b0;
            end
            for (int k = 0; k < 120; k++)
                send_matrix(rand_matrix());
        join
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(440, 7, 64);
        test_random(440, 64, 7);
        test_backpressure();
        test_random(330, 0, 0);
        repeat (100) @(posedge clk);
        $display("tb: %0d matrices sent, %0d results checked", n_sent, n_checked);
        $display("tb: %0d singular, %0d saturated", n_singular, n_sat);
        if (n_errors == 0 && pending_inv.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
